// ----- rtl/bhpc_pkg.sv -----
// Package of the boiler heater pulse controller: shared types, codes and
// fixed-point constants. Used by every module of the block; depends on nothing.

package bhpc_pkg;

  // Signed working width for temperature comparisons (quarter-hundredths fit).
  localparam int WideW = 24;
  typedef logic signed [WideW-1:0] wide_t;

  // Width of the pulse interpolation accumulator.
  localparam int AccW = 26;

  // Divider geometry: the pulse length over the brew divider.
  localparam int DivNumW = 16;
  localparam int DivDenW = 4;
  localparam int DivCntW = 5;

  // APB address width: six registers at word spacing.
  localparam int ApbAw = 5;

  // Register indexes on the configuration port.
  localparam logic [2:0] RegTarget    = 3'd0;
  localparam logic [2:0] RegFullPower = 3'd1;
  localparam logic [2:0] RegLowPower  = 3'd2;
  localparam logic [2:0] RegBrewDiv   = 3'd3;
  localparam logic [2:0] RegMainDiv   = 3'd4;
  localparam logic [2:0] RegOvershoot = 3'd5;

  // Temperature bands, in hundredths of a degree.
  localparam wide_t BandFull    = 24'sd1000;
  localparam wide_t BandHalf    = 24'sd500;
  localparam wide_t BandHold    = 24'sd25;
  localparam wide_t BandBrewLow = 24'sd150;

  // Pulse interpolation and overshoot rounding constants.
  localparam logic [9:0]      InterpSpan  = 10'd1000;
  localparam logic [AccW-1:0] InterpRound = 26'd500;
  localparam logic [9:0]      OsStep      = 10'd400;
  localparam logic [17:0]     OsHalf      = 18'd200;
  localparam logic [7:0]      PressPreinf = 8'd30;

  // Reciprocals for the constant divisions: x/1000 is (x>>3)*ceil(2^30/125)>>30
  // and x/400 is (x>>4)*ceil(2^18/25)>>18, exact over the operand ranges used.
  localparam logic [23:0] PwRecip = 24'd8589935;
  localparam logic [13:0] OsRecip = 14'd10486;

  // Iteration count of the division by the brew divider.
  localparam logic [DivCntW-1:0] DivCntBd = 5'd16;

  // Relay command codes.
  typedef enum logic [1:0] {
    ACT_KEEP = 2'd0,
    ACT_ON   = 2'd1,
    ACT_OFF  = 2'd2
  } bhpc_action_e;

  // Configuration register set.
  typedef struct packed {
    logic [16:0] tgt;
    logic [15:0] full;
    logic [15:0] low;
    logic [3:0]  bd;
    logic [3:0]  md;
    logic        oe;
  } bhpc_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic prep;
    logic mul_full;
    logic mul_low;
    logic recip;
    logic pw_load;
    logic div_start;
    logic bd_load;
    logic prod;
    logic commit;
  } bhpc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic out_free;
  } bhpc_sts_t;

endpackage

// ----- rtl/bhpc_if.sv -----
// Item channel interfaces of the boiler heater pulse controller.
// Input channel carries one sample, output channel one relay command.

interface bhpc_in_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] temperature;
  logic [31:0]        now_ms;
  logic               brew_active;
  logic [7:0]         target_pressure_tenths;

  modport source (output valid, output temperature, output now_ms,
                  output brew_active, output target_pressure_tenths, input ready);
  modport sink   (input valid, input temperature, input now_ms,
                  input brew_active, input target_pressure_tenths, output ready);
endinterface

interface bhpc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] boiler_action;
  logic       boiler_on;

  modport source (output valid, output boiler_action, output boiler_on, input ready);
  modport sink   (input valid, input boiler_action, input boiler_on, output ready);
endinterface

// ----- rtl/boiler_heater_pulse_controller.sv -----
// Boiler heater pulse controller, top level. One item at a time: the next item
// is accepted only after the result of the last one has been committed to the
// output register; a held result stalls the input. The 16-step division of the
// pulse length by the brew divider is the longest step of the sequence. Reset
// restores the register defaults, turns the relay off and clears switch time
// and phase.

module boiler_heater_pulse_controller
  import bhpc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  bhpc_in_if.sink          in_i,
  bhpc_out_if.source       out_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [ApbAw-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  bhpc_cfg_t cfg_q;
  bhpc_cmd_t cmd;
  bhpc_sts_t sts;
  logic      cfg_wr;

  // Configuration registers, written in the APB access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tgt  <= 17'd9300;
      cfg_q.full <= 16'd550;
      cfg_q.low  <= 16'd110;
      cfg_q.bd   <= 4'd2;
      cfg_q.md   <= 4'd5;
      cfg_q.oe   <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[ApbAw-1:2])
        RegTarget:    cfg_q.tgt  <= pwdata[16:0];
        RegFullPower: cfg_q.full <= pwdata[15:0];
        RegLowPower:  cfg_q.low  <= pwdata[15:0];
        RegBrewDiv:   cfg_q.bd   <= pwdata[3:0];
        RegMainDiv:   cfg_q.md   <= pwdata[3:0];
        RegOvershoot: cfg_q.oe   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[ApbAw-1:2])
      RegTarget:    prdata = {15'b0, cfg_q.tgt};
      RegFullPower: prdata = {16'b0, cfg_q.full};
      RegLowPower:  prdata = {16'b0, cfg_q.low};
      RegBrewDiv:   prdata = {28'b0, cfg_q.bd};
      RegMainDiv:   prdata = {28'b0, cfg_q.md};
      RegOvershoot: prdata = {31'b0, cfg_q.oe};
      default:      prdata = '0;
    endcase
  end

  bhpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bhpc_dp u_dp (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_i                    (cfg_q),
    .temperature_i            (in_i.temperature),
    .now_ms_i                 (in_i.now_ms),
    .brew_active_i            (in_i.brew_active),
    .target_pressure_tenths_i (in_i.target_pressure_tenths),
    .cmd_i                    (cmd),
    .sts_o                    (sts),
    .out_ready_i              (out_o.ready),
    .out_valid_o              (out_o.valid),
    .boiler_action_o          (out_o.boiler_action),
    .boiler_on_o              (out_o.boiler_on)
  );

`ifndef SYNTHESIS
  // A switch-on command always leaves the relay on.
  a_on_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.boiler_action == ACT_ON) |-> out_o.boiler_on)
    else $error("switch-on result with relay off");

  // A switch-off command always leaves the relay off.
  a_off_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.boiler_action == ACT_OFF) |-> !out_o.boiler_on)
    else $error("switch-off result with relay on");

  // The block never takes an item while a result is being formed.
  a_idle_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input ready straight after an accepted item");
`endif

endmodule

// ----- rtl/bhpc_div.sv -----
// Restoring divider, one quotient bit per cycle, MSB first.
// Depends on bhpc_pkg for its widths.

module bhpc_div
  import bhpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] dividend_i,
  input  logic [DivDenW-1:0] divisor_i,
  input  logic [DivCntW-1:0] count_i,
  output logic               done_o,
  output logic [DivNumW-1:0] quotient_o
);

  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [DivNumW-1:0] num_q, num_d;
  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivDenW-1:0] den_q, den_d;
  logic [DivDenW:0]   trial;
  logic [DivDenW:0]   diff;
  logic               fits;

  // Trial subtraction of one step.
  assign trial = {rem_q, num_q[DivNumW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  // Step sequencing: load on start, then shift one bit a cycle.
  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      cnt_d = count_i;
      num_d = dividend_i;
      quo_d = '0;
      rem_d = '0;
      den_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == DivCntW'(1));
      num_d  = {num_q[DivNumW-2:0], 1'b0};
      quo_d  = {quo_q[DivNumW-2:0], fits};
      rem_d  = fits ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Operand registers need no reset.
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/bhpc_ctrl.sv -----
// Controller of the boiler heater pulse controller: sequences the datapath
// through its multiply, divide and decide steps. Depends on bhpc_pkg.

module bhpc_ctrl
  import bhpc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  bhpc_sts_t sts_i,
  output bhpc_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_FULL,
    ST_MUL_LOW,
    ST_RECIP,
    ST_CLAMP,
    ST_DIV_BD,
    ST_WAIT_BD,
    ST_PROD,
    ST_DECIDE
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d = ST_MUL_FULL;
      end
      ST_MUL_FULL: begin
        cmd_o.mul_full = 1'b1;
        state_d = ST_MUL_LOW;
      end
      ST_MUL_LOW: begin
        cmd_o.mul_low = 1'b1;
        state_d = ST_RECIP;
      end
      ST_RECIP: begin
        cmd_o.recip = 1'b1;
        state_d = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd_o.pw_load = 1'b1;
        state_d = ST_DIV_BD;
      end
      ST_DIV_BD: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_WAIT_BD;
      end
      ST_WAIT_BD: begin
        if (sts_i.div_done) begin
          cmd_o.bd_load = 1'b1;
          state_d = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd_o.prod = 1'b1;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        // Wait here until the output register can take the result.
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  // The divider only finishes while the sequencer is waiting for it.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == ST_WAIT_BD))
    else $error("divider finished outside a wait state");

  // A blocked result keeps the sequencer in the decide step.
  a_decide_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE && !sts_i.out_free) |=> (state_q == ST_DECIDE))
    else $error("result dropped while output register was full");

  // No second item is taken straight after one is captured.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> !in_ready_o)
    else $error("item accepted while another is in progress");
`endif

endmodule

// ----- rtl/bhpc_dp.sv -----
// Datapath of the boiler heater pulse controller: operand registers, the
// pulse length arithmetic, band decision, relay state and output register.
// Depends on bhpc_pkg and bhpc_div.

module bhpc_dp
  import bhpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bhpc_cfg_t          cfg_i,
  input  logic signed [17:0] temperature_i,
  input  logic [31:0]        now_ms_i,
  input  logic               brew_active_i,
  input  logic [7:0]         target_pressure_tenths_i,
  input  bhpc_cmd_t          cmd_i,
  output bhpc_sts_t          sts_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [1:0]         boiler_action_o,
  output logic               boiler_on_o
);

  // Captured item.
  logic signed [17:0] t_q;
  logic [31:0]        now_q;
  logic               brew_q;
  logic               pf_q;

  // Intermediate results.
  logic [9:0]         d_q;
  logic [16:0]        v_q;
  logic [AccW-1:0]    acc_q;
  logic [15:0]        pwraw_q;
  logic [15:0]        pw_q;
  logic [15:0]        pwd_q;
  logic [8:0]         qos_q;
  logic [17:0]        dq_q;
  logic [19:0]        pwbd_q;
  logic [19:0]        lowmd_q;
  logic [19:0]        fullbd_q;
  logic [19:0]        fullmd_q;

  // Relay state and output register.
  logic [31:0]  last_switch_q;
  logic         phase_q;
  logic         relay_q;
  logic         out_valid_q;
  bhpc_action_e out_act_q;
  logic         out_on_q;

  // Effective dividers: zero acts as one.
  logic [3:0] bd_eff;
  logic [3:0] md_eff;
  assign bd_eff = (cfg_i.bd == '0) ? 4'd1 : cfg_i.bd;
  assign md_eff = (cfg_i.md == '0) ? 4'd1 : cfg_i.md;

  // Signed views of temperature and target.
  wide_t t_s, tgt_s, t4, tg4, dq_s, os_add;
  assign t_s    = {{(WideW-18){t_q[17]}}, t_q};
  assign tgt_s  = $signed({{(WideW-17){1'b0}}, cfg_i.tgt});
  assign t4     = t_s <<< 2;
  assign tg4    = tgt_s <<< 2;
  assign dq_s   = $signed({{(WideW-18){1'b0}}, dq_q});
  assign os_add = cfg_i.oe ? dq_s : '0;

  // Interpolation position and overshoot allowance before rounding.
  wide_t diff_d, e4;
  logic [9:0]  d_next;
  logic [16:0] v_next;
  assign diff_d = t_s - tgt_s + BandFull;
  assign e4     = (t_s - tgt_s) <<< 2;

  always_comb begin
    if (diff_d < 0) begin
      d_next = '0;
    end else if (diff_d > BandFull) begin
      d_next = InterpSpan;
    end else begin
      d_next = diff_d[9:0];
    end
    if (e4 <= 0) begin
      v_next = cfg_i.tgt;
    end else if (e4 >= tgt_s) begin
      v_next = '0;
    end else begin
      v_next = 17'(tgt_s - e4);
    end
  end

  // Constant divisions by reciprocal multiplication: the interpolated sum
  // over 1000 and the rounded allowance over 400.
  logic [17:0] v_round;
  logic [46:0] pw_recip;
  logic [27:0] os_recip;
  assign v_round  = {1'b0, v_q} + OsHalf;
  assign pw_recip = {24'b0, acc_q[AccW-1:3]} * {23'b0, PwRecip};
  assign os_recip = {14'b0, v_round[17:4]} * {14'b0, OsRecip};

  // Bit-serial division of the pulse length by the brew divider.
  logic               div_done;
  logic [DivNumW-1:0] div_quo;

  bhpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (pw_q),
    .divisor_i  (bd_eff),
    .count_i    (DivCntBd),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Pulse length clamped to the low and full periods.
  logic [15:0] pw_next;
  always_comb begin
    if (pwraw_q < cfg_i.low) begin
      pw_next = cfg_i.low;
    end else if (pwraw_q > cfg_i.full) begin
      pw_next = cfg_i.full;
    end else begin
      pw_next = pwraw_q;
    end
  end

  // Rounded allowance capped at the target.
  logic [17:0] os_prod;
  assign os_prod = 18'(qos_q * OsStep);

  // Band decision and pulse timing.
  logic [31:0]  elapsed;
  logic         pulsing;
  logic         on_first;
  logic [19:0]  on_wait;
  logic [19:0]  off_wait;
  bhpc_action_e act;
  logic         toggle;
  logic         relay_next;
  assign elapsed = now_q - last_switch_q;

  always_comb begin
    pulsing  = 1'b0;
    on_first = 1'b1;
    on_wait  = '0;
    off_wait = '0;
    act      = ACT_KEEP;
    toggle   = 1'b0;
    if (brew_q) begin
      if (t_s > tgt_s && t_s < tgt_s + BandHold && !pf_q) begin
        pulsing  = 1'b1;
        on_wait  = pwbd_q;
        off_wait = lowmd_q;
        on_first = 1'b0;
      end else if (t_s > tgt_s - BandBrewLow && t4 < tg4 + os_add && pf_q) begin
        pulsing  = 1'b1;
        on_wait  = fullbd_q;
        off_wait = {4'b0, cfg_i.full};
      end else if (cfg_i.oe && t4 >= tg4 + dq_s && t4 <= tg4 + dq_s + BandFull &&
                   pf_q) begin
        pulsing  = 1'b1;
        on_wait  = fullmd_q;
        off_wait = {4'b0, cfg_i.full};
      end else if (t_s <= tgt_s - BandBrewLow) begin
        act = ACT_ON;
      end else begin
        act = ACT_OFF;
      end
    end else begin
      if (t_s < tgt_s - BandFull) begin
        act = ACT_ON;
      end else if (t_s < tgt_s - BandHalf) begin
        pulsing  = 1'b1;
        on_wait  = {4'b0, pw_q};
        off_wait = {4'b0, pwd_q};
      end else if (t_s <= tgt_s - BandHold) begin
        pulsing  = 1'b1;
        on_wait  = pwbd_q;
        off_wait = {4'b0, pwd_q};
      end else begin
        act = ACT_OFF;
      end
    end
    // A pulse phase ends once its wait has passed.
    if (pulsing) begin
      if (!phase_q && elapsed > {12'b0, on_wait}) begin
        act    = on_first ? ACT_ON : ACT_OFF;
        toggle = 1'b1;
      end else if (phase_q && elapsed > {12'b0, off_wait}) begin
        act    = on_first ? ACT_OFF : ACT_ON;
        toggle = 1'b1;
      end
    end
    case (act)
      ACT_ON:  relay_next = 1'b1;
      ACT_OFF: relay_next = 1'b0;
      default: relay_next = relay_q;
    endcase
  end

  // Operand and intermediate registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      t_q    <= temperature_i;
      now_q  <= now_ms_i;
      brew_q <= brew_active_i;
      pf_q   <= brew_active_i && (target_pressure_tenths_i > PressPreinf);
    end
    if (cmd_i.prep) begin
      d_q <= d_next;
      v_q <= v_next;
    end
    if (cmd_i.mul_full) begin
      acc_q <= AccW'(cfg_i.full * (InterpSpan - d_q));
    end
    if (cmd_i.mul_low) begin
      acc_q <= acc_q + AccW'(cfg_i.low * d_q) + InterpRound;
    end
    if (cmd_i.recip) begin
      pwraw_q <= pw_recip[45:30];
      qos_q   <= os_recip[26:18];
    end
    if (cmd_i.pw_load) begin
      pw_q <= pw_next;
    end
    if (cmd_i.bd_load) begin
      pwd_q <= div_quo;
    end
    if (cmd_i.prod) begin
      dq_q     <= (os_prod > {1'b0, cfg_i.tgt}) ? {1'b0, cfg_i.tgt} : os_prod;
      pwbd_q   <= 20'(pw_q * bd_eff);
      lowmd_q  <= 20'(cfg_i.low * md_eff);
      fullbd_q <= 20'(cfg_i.full * bd_eff);
      fullmd_q <= 20'(cfg_i.full * md_eff);
    end
    if (cmd_i.commit) begin
      out_act_q <= act;
      out_on_q  <= relay_next;
    end
  end

  // Relay state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_switch_q <= '0;
      phase_q       <= 1'b0;
      relay_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        relay_q <= relay_next;
        if (toggle) begin
          phase_q       <= !phase_q;
          last_switch_q <= now_q;
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign boiler_action_o = out_act_q;
  assign boiler_on_o     = out_on_q;

endmodule
